FILE: sv/tcbpm_pkg.sv
`default_nettype none

package tcbpm_pkg;

  // Pool geometry
  localparam int SMALL_COUNT = 13;
  localparam int LARGE_COUNT = 8;
  localparam int FIFO_DEPTH  = SMALL_COUNT + LARGE_COUNT;

  // Field widths
  localparam int OP_W      = 3;
  localparam int SIZE_W    = 16;
  localparam int ID_W      = 5;
  localparam int CFG_IDX_W = 1;

  localparam int SMALL_IDX_W = (SMALL_COUNT > 1) ? $clog2(SMALL_COUNT) : 1;
  localparam int LARGE_IDX_W = (LARGE_COUNT > 1) ? $clog2(LARGE_COUNT) : 1;
  localparam int PTR_W       = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);

  // Operation codes
  localparam logic [OP_W-1:0] OP_ALLOC   = 3'd0;
  localparam logic [OP_W-1:0] OP_FREE    = 3'd1;
  localparam logic [OP_W-1:0] OP_ENQUEUE = 3'd2;
  localparam logic [OP_W-1:0] OP_DEQUEUE = 3'd3;
  localparam logic [OP_W-1:0] OP_GROW    = 3'd4;
  localparam logic [OP_W-1:0] OP_CHECK   = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SMALL_BYTES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LARGE_BYTES = 1'b1;

  localparam logic [SIZE_W-1:0] SMALL_BYTES_RST = 16'd64;
  localparam logic [SIZE_W-1:0] LARGE_BYTES_RST = 16'd256;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [SIZE_W-1:0] request_size;
    logic [ID_W-1:0]   target_buffer;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0] result_buffer;
    logic            result_valid;
    logic            buffer_is_free;
    logic            queue_overflow;
  } res_t;

  typedef struct packed {
    logic [SIZE_W-1:0] small_bytes;
    logic [SIZE_W-1:0] large_bytes;
  } cfg_t;

  typedef struct packed {
    logic                   found;
    logic [SMALL_IDX_W-1:0] idx;
  } small_hit_t;

  typedef struct packed {
    logic                   found;
    logic [LARGE_IDX_W-1:0] idx;
  } large_hit_t;

  // Lowest clear bit of the small busy marks
  function automatic small_hit_t first_free_small(input logic [SMALL_COUNT-1:0] marks);
    small_hit_t h;
    h = '0;
    for (int i = SMALL_COUNT - 1; i >= 0; i--) begin
      if (!marks[i]) begin
        h.found = 1'b1;
        h.idx   = SMALL_IDX_W'(i);
      end
    end
    return h;
  endfunction

  // Lowest clear bit of the large busy marks
  function automatic large_hit_t first_free_large(input logic [LARGE_COUNT-1:0] marks);
    large_hit_t h;
    h = '0;
    for (int i = LARGE_COUNT - 1; i >= 0; i--) begin
      if (!marks[i]) begin
        h.found = 1'b1;
        h.idx   = LARGE_IDX_W'(i);
      end
    end
    return h;
  endfunction

endpackage

`default_nettype wire

FILE: sv/tcbpm_in_if.sv
`default_nettype none

// Operation request channel
interface tcbpm_in_if;
  logic                          valid;
  logic                          ready;
  logic [tcbpm_pkg::OP_W-1:0]    operation;
  logic [tcbpm_pkg::SIZE_W-1:0]  request_size;
  logic [tcbpm_pkg::ID_W-1:0]    target_buffer;

  modport source (output valid, output operation, output request_size,
                  output target_buffer, input ready);
  modport sink   (input valid, input operation, input request_size,
                  input target_buffer, output ready);
endinterface

`default_nettype wire

FILE: sv/tcbpm_out_if.sv
`default_nettype none

// Result channel
interface tcbpm_out_if;
  logic                        valid;
  logic                        ready;
  logic [tcbpm_pkg::ID_W-1:0]  result_buffer;
  logic                        result_valid;
  logic                        buffer_is_free;
  logic                        queue_overflow;

  modport source (output valid, output result_buffer, output result_valid,
                  output buffer_is_free, output queue_overflow, input ready);
  modport sink   (input valid, input result_buffer, input result_valid,
                  input buffer_is_free, input queue_overflow, output ready);
endinterface

`default_nettype wire

FILE: sv/tcbpm_cfg_if.sv
`default_nettype none

// Configuration write channel
interface tcbpm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [tcbpm_pkg::CFG_IDX_W-1:0]  index;
  logic [tcbpm_pkg::SIZE_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/tcbpm_pool.sv
`default_nettype none

// Busy bitmaps, ready FIFO and the per-request update logic.
module tcbpm_pool (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,
  input  wire tcbpm_pkg::req_t req,
  input  wire tcbpm_pkg::cfg_t cfg,
  output tcbpm_pkg::res_t      res
);

  logic [tcbpm_pkg::SMALL_COUNT-1:0] small_busy_r, small_busy_nxt;
  logic [tcbpm_pkg::LARGE_COUNT-1:0] large_busy_r, large_busy_nxt;
  logic [tcbpm_pkg::PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [tcbpm_pkg::PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [tcbpm_pkg::CNT_W-1:0]       fill_cnt_r, fill_cnt_nxt;
  logic [tcbpm_pkg::ID_W-1:0]        fifo_r [tcbpm_pkg::FIFO_DEPTH];
  logic                              fifo_we;

  tcbpm_pkg::small_hit_t             small_hit;
  tcbpm_pkg::large_hit_t             large_hit;
  logic                              is_small;
  logic                              is_large;
  logic [tcbpm_pkg::SMALL_IDX_W-1:0] sm_idx;
  logic [tcbpm_pkg::LARGE_IDX_W-1:0] lg_idx;
  logic [tcbpm_pkg::ID_W-1:0]        large_id;

  // Target classification and free-slot search
  always_comb begin
    small_hit = tcbpm_pkg::first_free_small(small_busy_r);
    large_hit = tcbpm_pkg::first_free_large(large_busy_r);
    is_small  = req.target_buffer < tcbpm_pkg::ID_W'(tcbpm_pkg::SMALL_COUNT);
    is_large  = !is_small &&
                (req.target_buffer < tcbpm_pkg::ID_W'(tcbpm_pkg::FIFO_DEPTH));
    sm_idx    = req.target_buffer[tcbpm_pkg::SMALL_IDX_W-1:0];
    lg_idx    = tcbpm_pkg::LARGE_IDX_W'(req.target_buffer -
                                        tcbpm_pkg::ID_W'(tcbpm_pkg::SMALL_COUNT));
    large_id  = tcbpm_pkg::ID_W'(tcbpm_pkg::SMALL_COUNT) +
                tcbpm_pkg::ID_W'(large_hit.idx);
  end

  // Operation decode and next state
  always_comb begin
    small_busy_nxt = small_busy_r;
    large_busy_nxt = large_busy_r;
    rd_ptr_nxt     = rd_ptr_r;
    wr_ptr_nxt     = wr_ptr_r;
    fill_cnt_nxt   = fill_cnt_r;
    fifo_we        = 1'b0;
    res            = '0;
    unique case (req.operation)
      tcbpm_pkg::OP_ALLOC: begin
        if (req.request_size < cfg.small_bytes) begin
          if (small_hit.found) begin
            small_busy_nxt[small_hit.idx] = 1'b1;
            res.result_buffer = tcbpm_pkg::ID_W'(small_hit.idx);
            res.result_valid  = 1'b1;
          end
        end else if (req.request_size < cfg.large_bytes) begin
          if (large_hit.found) begin
            large_busy_nxt[large_hit.idx] = 1'b1;
            res.result_buffer = large_id;
            res.result_valid  = 1'b1;
          end
        end
      end
      tcbpm_pkg::OP_FREE: begin
        if (is_small) begin
          small_busy_nxt[sm_idx] = 1'b0;
        end else if (is_large) begin
          large_busy_nxt[lg_idx] = 1'b0;
        end
      end
      tcbpm_pkg::OP_ENQUEUE: begin
        if (fill_cnt_r == tcbpm_pkg::CNT_W'(tcbpm_pkg::FIFO_DEPTH)) begin
          res.queue_overflow = 1'b1;
        end else begin
          fifo_we      = 1'b1;
          wr_ptr_nxt   = (wr_ptr_r == tcbpm_pkg::PTR_W'(tcbpm_pkg::FIFO_DEPTH - 1)) ?
                         '0 : wr_ptr_r + 1'b1;
          fill_cnt_nxt = fill_cnt_r + 1'b1;
        end
      end
      tcbpm_pkg::OP_DEQUEUE: begin
        if (fill_cnt_r != '0) begin
          res.result_buffer = fifo_r[rd_ptr_r];
          res.result_valid  = 1'b1;
          rd_ptr_nxt   = (rd_ptr_r == tcbpm_pkg::PTR_W'(tcbpm_pkg::FIFO_DEPTH - 1)) ?
                         '0 : rd_ptr_r + 1'b1;
          fill_cnt_nxt = fill_cnt_r - 1'b1;
        end
      end
      tcbpm_pkg::OP_GROW: begin
        if (is_small) begin
          res.result_buffer = req.target_buffer;
          res.result_valid  = 1'b1;
          // move to the lowest free large buffer when one exists and small_bytes < large_bytes
          if ((cfg.small_bytes < cfg.large_bytes) && large_hit.found) begin
            large_busy_nxt[large_hit.idx] = 1'b1;
            small_busy_nxt[sm_idx]        = 1'b0;
            res.result_buffer             = large_id;
          end
        end else if (is_large) begin
          res.result_buffer = req.target_buffer;
          res.result_valid  = 1'b1;
        end
      end
      tcbpm_pkg::OP_CHECK: begin
        if (is_small) begin
          res.buffer_is_free = !small_busy_r[sm_idx];
        end else if (is_large) begin
          res.buffer_is_free = !large_busy_r[lg_idx];
        end
      end
      default: begin
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      small_busy_r <= '0;
      large_busy_r <= '0;
      rd_ptr_r     <= '0;
      wr_ptr_r     <= '0;
      fill_cnt_r   <= '0;
    end else if (step) begin
      small_busy_r <= small_busy_nxt;
      large_busy_r <= large_busy_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
      wr_ptr_r     <= wr_ptr_nxt;
      fill_cnt_r   <= fill_cnt_nxt;
    end
  end

  // FIFO storage, no reset
  always_ff @(posedge clk) begin
    if (step && fifo_we) begin
      fifo_r[wr_ptr_r] <= req.target_buffer;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_cnt_r <= tcbpm_pkg::CNT_W'(tcbpm_pkg::FIFO_DEPTH))
    else $error("fifo fill count above depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_cnt_r == '0) |-> (rd_ptr_r == wr_ptr_r))
    else $error("empty fifo with unequal pointers");

  a_full_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_cnt_r == tcbpm_pkg::CNT_W'(tcbpm_pkg::FIFO_DEPTH)) |-> (rd_ptr_r == wr_ptr_r))
    else $error("full fifo with unequal pointers");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_ptr_r < tcbpm_pkg::PTR_W'(tcbpm_pkg::FIFO_DEPTH)) &&
    (wr_ptr_r < tcbpm_pkg::PTR_W'(tcbpm_pkg::FIFO_DEPTH)))
    else $error("fifo pointer out of range");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(small_busy_r) && $stable(large_busy_r) && $stable(fill_cnt_r))
    else $error("pool state changed without a request");

endmodule

`default_nettype wire

FILE: sv/two_class_buffer_pool_manager.sv
// Two-class buffer pool manager.
// Tracks busy marks for small buffers (ids 0..12) and large buffers
// (ids 13..20) and a 21-deep FIFO of buffer ids queued for processing.
// in_req carries one request: operation (alloc, free, enqueue, dequeue,
// grow, check), request_size for alloc and target_buffer for the rest.
// out_res returns exactly one result per request, in request order.
// cfg_wr writes small_buffer_bytes (index 0) and large_buffer_bytes
// (index 1); it is always ready and must only be used while idle.
// A request accepted into the input register is processed against the pool
// into the result register, where out_res can take it. Throughput is one
// request per cycle while out_res does not stall; the bitmap/FIFO update
// between the two registers is combinational.
// Reset (rst_n low, synchronous) marks all buffers free, empties the
// FIFO and restores 64/256 byte capacities. When out_res stalls, the
// result is held and one more request can sit in the input register;
// in_req.ready then drops until the output drains.
`default_nettype none

module two_class_buffer_pool_manager (
  input  wire logic   clk,
  input  wire logic   rst_n,
  tcbpm_in_if.sink    in_req,
  tcbpm_out_if.source out_res,
  tcbpm_cfg_if.sink   cfg_wr
);

  tcbpm_pkg::cfg_t cfg_r, cfg_nxt;
  tcbpm_pkg::req_t s1_req_r;
  logic            s1_valid_r, s1_valid_nxt;
  tcbpm_pkg::res_t s2_res_r;
  logic            s2_valid_r, s2_valid_nxt;
  tcbpm_pkg::res_t pool_res;
  logic            in_acc;
  logic            step;

  // Configuration registers
  assign cfg_wr.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        tcbpm_pkg::REG_SMALL_BYTES: cfg_nxt.small_bytes = cfg_wr.data;
        tcbpm_pkg::REG_LARGE_BYTES: cfg_nxt.large_bytes = cfg_wr.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.small_bytes <= tcbpm_pkg::SMALL_BYTES_RST;
      cfg_r.large_bytes <= tcbpm_pkg::LARGE_BYTES_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Pipeline handshake
  assign step          = s1_valid_r && (!s2_valid_r || out_res.ready);
  assign in_req.ready  = !s1_valid_r || step;
  assign in_acc        = in_req.valid && in_req.ready;
  assign s1_valid_nxt  = in_acc || (s1_valid_r && !step);
  assign s2_valid_nxt  = step || (s2_valid_r && !out_res.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r.operation     <= in_req.operation;
      s1_req_r.request_size  <= in_req.request_size;
      s1_req_r.target_buffer <= in_req.target_buffer;
    end
  end

  tcbpm_pool u_pool (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .req   (s1_req_r),
    .cfg   (cfg_r),
    .res   (pool_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (step) begin
      s2_res_r <= pool_res;
    end
  end

  assign out_res.valid          = s2_valid_r;
  assign out_res.result_buffer  = s2_res_r.result_buffer;
  assign out_res.result_valid   = s2_res_r.result_valid;
  assign out_res.buffer_is_free = s2_res_r.buffer_is_free;
  assign out_res.queue_overflow = s2_res_r.queue_overflow;

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !out_res.ready) |=> s2_valid_r)
    else $error("stalled result lost");

  a_step_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    step |-> (!s2_valid_r || out_res.ready))
    else $error("result register overwritten");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !step) |=> (s1_valid_r && $stable(s1_req_r)))
    else $error("pending request lost");

endmodule

`default_nettype wire
